// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the motion profile block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TMP_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TMP_ASSERT(label, prop, msg)
`define TMP_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ----- src/tmp_pkg.sv -----
// Shared constants, codes and types of the trapezoid motion profile block.
package tmp_pkg;
    localparam int TIME_BITS_DEF = 32;
    localparam int DQ_W          = 23;
    localparam int DT_CAP_LOG    = 22;
    localparam int A_BITS        = 6;
    localparam int V_BITS        = 9;
    localparam int L_BITS        = 14;
    localparam int MUL_CNT_W     = 5;
    localparam int QDIV_N_W      = 52;
    localparam int QDIV_D_W      = 11;
    localparam int QUAD_DIVISOR  = 2000;
    localparam int POS_LIMIT     = 10000000;
    localparam int SPEED_LIMIT   = 500000;
    localparam int P1_W          = 29;

    localparam logic [2:0] PH_ACCEL      = 3'd0;
    localparam logic [2:0] PH_CRUISE     = 3'd1;
    localparam logic [2:0] PH_DECEL      = 3'd2;
    localparam logic [2:0] PH_HOLD       = 3'd3;
    localparam logic [2:0] PH_BACK_ACCEL = 3'd4;
    localparam logic [2:0] PH_BACK_CRUISE= 3'd5;
    localparam logic [2:0] PH_BACK_DECEL = 3'd6;
    localparam logic [2:0] PH_IDLE       = 3'd7;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_EXTEND  = 2'd1;
    localparam logic [1:0] KIND_RETRACT = 2'd2;
    localparam logic [1:0] KIND_ABORT   = 2'd3;

    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_SPEED  = 2'd1;
    localparam logic [1:0] CFG_ACCEL  = 2'd2;

    typedef struct packed {
        logic                 start;
        logic [MUL_CNT_W-1:0] len;
    } mul_cmd_t;
endpackage

// ----- src/tmp_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module tmp_mul #(
    parameter int MC_W = 32,
    parameter int ML_W = 23
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tmp_pkg::mul_cmd_t       cmd,
    input  logic [MC_W-1:0]         mcand,
    input  logic [ML_W-1:0]         mlier,
    output logic [MC_W+ML_W-1:0]    product,
    output logic                    done
);
    import tmp_pkg::*;

    localparam int PW = MC_W + ML_W;

    logic [PW-1:0]        acc_reg;
    logic [PW-1:0]        mc_reg;
    logic [ML_W-1:0]      ml_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_CNT_W-1:0] len_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == len_reg - MUL_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= '0;
            mc_reg  <= PW'(mcand);
            ml_reg  <= mlier;
            cnt_reg <= '0;
            len_reg <= cmd.len;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicand when the current bit is set
            if (ml_reg[0])
            begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg  <= mc_reg << 1;
            ml_reg  <= ml_reg >> 1;
            cnt_reg <= cnt_reg + MUL_CNT_W'(1);
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;
endmodule

// ----- src/tmp_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tmp_div #(
    parameter int N_W = 9,
    parameter int D_W = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [N_W-1:0] quotient,
    output logic           done
);
    localparam int CW = $clog2(N_W);

    logic [N_W-1:0] dvd_reg;
    logic [D_W-1:0] rem_reg;
    logic [D_W-1:0] dsr_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [D_W:0]   trial;
    logic           fits;

    assign trial = {rem_reg, dvd_reg[N_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == CW'(N_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, keep the quotient bit in its place
            rem_reg <= fits ? D_W'(trial - {1'b0, dsr_reg}) : D_W'(trial);
            dvd_reg <= {dvd_reg[N_W-2:0], fits};
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;
endmodule

// ----- src/trapezoid_motion_profile.sv -----
// Top level of the trapezoid motion profile generator.
// Each input word is one timed event (tick, start extension, start retraction,
// abort) and yields exactly one output word: phase, position in um, speed in
// um/s and acceleration in mm/s^2. Start, abort and ticks in the hold or idle
// phase pass through the S_FIN state to the output register, loaded once the
// output is free. For a tick in a moving phase a bit-serial multiplier forms
// a*dt, then a*dt*dt, then v*dt beside the bit-serial division of the
// quadratic term by 2000, which ends last; each serial step is started by a
// registered strobe, its result is taken when done, and S_FIN then loads the
// output register. The ramp time quotient speed/accel is divided out beside
// the first products. A new word is taken once the previous one sits in the
// output register. Configuration is written through cfg_we/cfg_index/cfg_data
// while idle; the user must keep to this, the block does not enforce it.
module trapezoid_motion_profile #(
    parameter int TIME_BITS = tmp_pkg::TIME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [13:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic [31:0]         elapsed_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          phase,
    output logic signed [24:0]  position_um,
    output logic [18:0]         speed_um_s,
    output logic [5:0]          accel_out_mm_s2
);
    import tmp_pkg::*;

    `include "assert_macros.svh"

    localparam int TW    = TIME_BITS;
    localparam int MC_W  = (TW > P1_W) ? TW : P1_W;
    localparam int PW    = MC_W + DQ_W;
    localparam int SW    = (TW + 11 > 42) ? TW + 11 : 42;
    localparam int DTX_W = (TW > DQ_W) ? TW : DQ_W;
    localparam int P3_W  = TW + V_BITS;

    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_TAIL, S_FIN} state_t;

    state_t state_reg, state_next;

    // configuration
    logic [L_BITS-1:0] tgt_reg;
    logic [V_BITS-1:0] spd_reg;
    logic [A_BITS-1:0] acc_reg;

    // per-event working registers
    logic [1:0]          kind_reg, kind_next;
    logic [TW-1:0]       now_reg, now_next;
    logic [TW-1:0]       dt_reg, dt_next;
    logic [V_BITS-1:0]   ratio_reg, ratio_next;
    logic [P1_W-1:0]     p1_reg, p1_next;
    logic [QDIV_N_W-1:0] p2_reg, p2_next;
    logic [P3_W-1:0]     p3_reg, p3_next;
    logic [QDIV_N_W-1:0] quad_reg, quad_next;
    logic                mstart_reg, mstart_next;
    logic                vstart_reg, vstart_next;
    logic                qstart_reg, qstart_next;

    // profile state
    logic [2:0]          ph_reg, ph_next;
    logic [TW-1:0]       seg_ms_reg, seg_ms_next;
    logic signed [24:0]  ssp_reg, ssp_next;
    logic signed [24:0]  hpos_reg, hpos_next;
    logic [18:0]         hspd_reg, hspd_next;
    logic [5:0]          hacc_reg, hacc_next;

    // output register
    logic                ovalid_reg, ovalid_next;
    logic [2:0]          ophase_reg, ophase_next;
    logic signed [24:0]  opos_reg, opos_next;
    logic [18:0]         ospd_reg, ospd_next;
    logic [5:0]          oacc_reg, oacc_next;

    // datapath
    mul_cmd_t            mul_cmd;
    logic [MC_W-1:0]     mul_mcand;
    logic [DQ_W-1:0]     mul_mlier;
    logic [PW-1:0]       mul_prod;
    logic                mul_done;
    logic [V_BITS-1:0]   vdiv_q;
    logic                vdiv_done;
    logic [QDIV_N_W-1:0] qdiv_q;
    logic                qdiv_done;

    logic [TW-1:0]       now_in;
    logic [A_BITS-1:0]   a_eff;
    logic [DTX_W-1:0]    dt_x;
    logic [DQ_W-1:0]     dq;
    logic [18:0]         ramp_ms;
    logic                ramp_done;
    logic                accept;
    logic                moving;
    logic                out_free;
    logic signed [SW-1:0] len_s, vum_s, p1_s, p3_s, quad_s, ssp_s, sum_s;
    logic signed [24:0]  pos_t;
    logic signed [SW-1:0] pos_x;

    function automatic logic signed [24:0] sat_pos(input logic signed [SW-1:0] p);
        if (p > SW'(POS_LIMIT))
        begin
            return 25'(POS_LIMIT);
        end
        else if (p < SW'(-POS_LIMIT))
        begin
            return 25'(-POS_LIMIT);
        end
        return 25'(p);
    endfunction

    function automatic logic [18:0] sat_spd(input logic signed [SW-1:0] s);
        if (s > SW'(SPEED_LIMIT))
        begin
            return 19'(SPEED_LIMIT);
        end
        else if (s < SW'(0))
        begin
            return '0;
        end
        return 19'(s);
    endfunction

    // configuration writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg <= L_BITS'(2000);
            spd_reg <= V_BITS'(200);
            acc_reg <= A_BITS'(5);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET: tgt_reg <= cfg_data;
                CFG_SPEED:  spd_reg <= cfg_data[V_BITS-1:0];
                CFG_ACCEL:  acc_reg <= cfg_data[A_BITS-1:0];
                default:    ;
            endcase
        end
    end

    assign now_in   = TW'(elapsed_ms);
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !ovalid_reg || out_ready;
    assign moving   = (ph_reg != PH_HOLD) && (ph_reg != PH_IDLE);
    assign a_eff    = (acc_reg == '0) ? A_BITS'(1) : acc_reg;

    // ramp-term time is capped at 2^22 ms
    assign dt_x = DTX_W'(dt_reg);
    assign dq   = (dt_x >= DTX_W'(64'd1 << DT_CAP_LOG)) ? DQ_W'(64'd1 << DT_CAP_LOG)
                                                         : DQ_W'(dt_x);

    // ramp time = (v / a) * 1000 ms, formed from shifts
    assign ramp_ms   = 19'({ratio_reg, 10'd0}) - 19'({ratio_reg, 4'd0})
                     - 19'({ratio_reg, 3'd0});
    assign ramp_done = dt_x >= DTX_W'(ramp_ms);

    // serial unit operand select follows the sequencer state
    always_comb
    begin
        case (state_reg)
            S_MUL1:
            begin
                mul_mcand   = MC_W'(dq);
                mul_mlier   = DQ_W'(a_eff);
                mul_cmd.len = MUL_CNT_W'(A_BITS);
            end
            S_MUL2:
            begin
                mul_mcand   = MC_W'(p1_reg);
                mul_mlier   = dq;
                mul_cmd.len = MUL_CNT_W'(DQ_W);
            end
            default:
            begin
                mul_mcand   = MC_W'(dt_reg);
                mul_mlier   = DQ_W'(spd_reg);
                mul_cmd.len = MUL_CNT_W'(V_BITS);
            end
        endcase
        mul_cmd.start = mstart_reg;
    end

    tmp_mul #(.MC_W(MC_W), .ML_W(DQ_W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul_cmd),
        .mcand   (mul_mcand),
        .mlier   (mul_mlier),
        .product (mul_prod),
        .done    (mul_done)
    );

    tmp_div #(.N_W(V_BITS), .D_W(A_BITS)) u_vdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (vstart_reg),
        .dividend (spd_reg),
        .divisor  (a_eff),
        .quotient (vdiv_q),
        .done     (vdiv_done)
    );

    tmp_div #(.N_W(QDIV_N_W), .D_W(QDIV_D_W)) u_qdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (qstart_reg),
        .dividend (p2_reg),
        .divisor  (QDIV_D_W'(QUAD_DIVISOR)),
        .quotient (qdiv_q),
        .done     (qdiv_done)
    );

    // signed terms of the profile point
    assign len_s  = SW'({tgt_reg, 10'd0}) - SW'({tgt_reg, 4'd0}) - SW'({tgt_reg, 3'd0});
    assign vum_s  = SW'({spd_reg, 10'd0}) - SW'({spd_reg, 4'd0}) - SW'({spd_reg, 3'd0});
    assign p1_s   = SW'(p1_reg);
    assign p3_s   = SW'(p3_reg);
    assign quad_s = SW'(quad_reg);
    assign ssp_s  = SW'(ssp_reg);

    always_comb
    begin
        case (ph_reg)
            PH_ACCEL:       sum_s = quad_s;
            PH_CRUISE:      sum_s = ssp_s + p3_s;
            PH_DECEL:       sum_s = ssp_s + p3_s - quad_s;
            PH_BACK_ACCEL:  sum_s = len_s - quad_s;
            PH_BACK_CRUISE: sum_s = ssp_s - p3_s;
            default:        sum_s = ssp_s - p3_s - quad_s;
        endcase
    end

    assign pos_t = sat_pos(sum_s);
    assign pos_x = SW'(pos_t);

    // sequencer and profile state
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        now_next    = now_reg;
        dt_next     = dt_reg;
        ratio_next  = ratio_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        p3_next     = p3_reg;
        quad_next   = quad_reg;
        mstart_next = 1'b0;
        vstart_next = 1'b0;
        qstart_next = 1'b0;
        ph_next     = ph_reg;
        seg_ms_next = seg_ms_reg;
        ssp_next    = ssp_reg;
        hpos_next   = hpos_reg;
        hspd_next   = hspd_reg;
        hacc_next   = hacc_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ophase_next = ophase_reg;
        opos_next   = opos_reg;
        ospd_next   = ospd_reg;
        oacc_next   = oacc_reg;

        if (vdiv_done)
        begin
            ratio_next = vdiv_q;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = kind;
                    now_next  = now_in;
                    dt_next   = now_in - seg_ms_reg;
                    if (kind == KIND_TICK && moving)
                    begin
                        state_next  = S_MUL1;
                        mstart_next = 1'b1;
                        vstart_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MUL1:
            begin
                if (mul_done)
                begin
                    p1_next     = P1_W'(mul_prod);
                    mstart_next = 1'b1;
                    state_next  = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (mul_done)
                begin
                    p2_next     = QDIV_N_W'(mul_prod);
                    mstart_next = 1'b1;
                    qstart_next = 1'b1;
                    state_next  = S_TAIL;
                end
            end
            S_TAIL:
            begin
                // v*dt finishes well before the quadratic division
                if (mul_done)
                begin
                    p3_next = P3_W'(mul_prod);
                end
                if (qdiv_done)
                begin
                    quad_next  = qdiv_q;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    case (kind_reg)
                        KIND_EXTEND, KIND_RETRACT:
                        begin
                            ph_next     = (kind_reg == KIND_EXTEND) ? PH_ACCEL : PH_BACK_ACCEL;
                            seg_ms_next = now_reg;
                            ssp_next    = '0;
                        end
                        KIND_ABORT:
                        begin
                            ph_next   = PH_IDLE;
                            hpos_next = '0;
                            hspd_next = '0;
                            hacc_next = '0;
                        end
                        default:
                        begin
                            case (ph_reg)
                                PH_ACCEL, PH_BACK_ACCEL:
                                begin
                                    hacc_next = a_eff;
                                    hspd_next = sat_spd(p1_s);
                                    hpos_next = pos_t;
                                    if (ramp_done)
                                    begin
                                        ph_next     = ph_reg + 3'd1;
                                        seg_ms_next = now_reg;
                                        ssp_next    = pos_t;
                                    end
                                end
                                PH_CRUISE, PH_BACK_CRUISE:
                                begin
                                    hacc_next = '0;
                                    hspd_next = sat_spd(vum_s);
                                    hpos_next = pos_t;
                                    if ((ph_reg == PH_CRUISE && len_s - pos_x <= ssp_s) ||
                                        (ph_reg == PH_BACK_CRUISE && pos_x <= len_s - ssp_s))
                                    begin
                                        ph_next     = ph_reg + 3'd1;
                                        seg_ms_next = now_reg;
                                        ssp_next    = pos_t;
                                    end
                                end
                                PH_DECEL, PH_BACK_DECEL:
                                begin
                                    if (ramp_done)
                                    begin
                                        hpos_next = (ph_reg == PH_DECEL) ? sat_pos(len_s) : '0;
                                        hspd_next = '0;
                                        hacc_next = '0;
                                        ph_next   = ph_reg + 3'd1;
                                    end
                                    else
                                    begin
                                        hacc_next = a_eff;
                                        hspd_next = sat_spd(vum_s - p1_s);
                                        hpos_next = pos_t;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    endcase
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (state_reg == S_FIN && out_free)
        begin
            ophase_next = ph_next;
            opos_next   = hpos_next;
            ospd_next   = hspd_next;
            oacc_next   = hacc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mstart_reg <= 1'b0;
            vstart_reg <= 1'b0;
            qstart_reg <= 1'b0;
            ph_reg     <= PH_IDLE;
            seg_ms_reg <= '0;
            ssp_reg    <= '0;
            hpos_reg   <= '0;
            hspd_reg   <= '0;
            hacc_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mstart_reg <= mstart_next;
            vstart_reg <= vstart_next;
            qstart_reg <= qstart_next;
            ph_reg     <= ph_next;
            seg_ms_reg <= seg_ms_next;
            ssp_reg    <= ssp_next;
            hpos_reg   <= hpos_next;
            hspd_reg   <= hspd_next;
            hacc_reg   <= hacc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        now_reg    <= now_next;
        dt_reg     <= dt_next;
        ratio_reg  <= ratio_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        p3_reg     <= p3_next;
        quad_reg   <= quad_next;
        ophase_reg <= ophase_next;
        opos_reg   <= opos_next;
        ospd_reg   <= ospd_next;
        oacc_reg   <= oacc_next;
    end

    assign out_valid       = ovalid_reg;
    assign phase           = ophase_reg;
    assign position_um     = opos_reg;
    assign speed_um_s      = ospd_reg;
    assign accel_out_mm_s2 = oacc_reg;

    // an accepted word always leaves the idle state
    `TMP_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accept did not start work")
    // hold and idle words carry no motion
    `TMP_ASSERT(a_rest_still, (out_valid && (phase == PH_HOLD || phase == PH_IDLE)) |-> (speed_um_s == '0 && accel_out_mm_s2 == '0), "motion at rest")
    // position always within its saturation range
    `TMP_ASSERT_NEVER(a_pos_range, out_valid && (position_um > 25'sd10000000 || position_um < -25'sd10000000), "position out of range")
endmodule

// ----- dv/trapezoid_motion_profile_tb.sv -----
// Self-checking testbench for the trapezoid motion profile generator.
module trapezoid_motion_profile_tb;
    import tmp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ms;
    } event_word_t;

    typedef struct packed {
        logic [2:0]         phase;
        logic signed [24:0] pos;
        logic [18:0]        spd;
        logic [5:0]         acc;
    } point_t;

    localparam longint POS_SAT  = 10000000;
    localparam longint SPD_SAT  = 500000;
    localparam longint DQ_LIMIT = 64'd1 << 22;
    localparam int     QUIET_LO = 2000;
    localparam int     QUIET_HI = 6000;
    localparam int     HOLD_AT  = 9000;
    localparam int     HOLD_LEN = 400;
    localparam int     WATCHDOG = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_TARGET;
    logic [13:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = KIND_TICK;
    logic [31:0] elapsed_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  phase;
    logic signed [24:0] position_um;
    logic [18:0] speed_um_s;
    logic [5:0]  accel_out_mm_s2;

    trapezoid_motion_profile i_dut (.*);

    always #1 clk = ~clk;

    // Pending stimulus, expected profile points, bookkeeping.
    event_word_t pending_events[$];
    point_t      expected_points[$];
    int          errors = 0;
    int          cycle = 0;
    int          idle_cycles = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          hold_left = 0;
    logic [31:0] clock_ms = '0;

    // Shadow registers and profile state.
    longint unsigned cfg_len = 2000, cfg_spd = 200, cfg_acc = 5;
    logic [2:0]      prof_phase = PH_IDLE;
    logic [31:0]     seg_ms = '0;
    longint          seg_pos = 0, keep_pos = 0, keep_spd = 0;
    longint unsigned keep_acc = 0;

    function automatic longint clamp_pos(longint p);
        if (p > POS_SAT) return POS_SAT;
        if (p < -POS_SAT) return -POS_SAT;
        return p;
    endfunction

    function automatic longint clamp_spd(longint s);
        if (s > SPD_SAT) return SPD_SAT;
        if (s < 0) return 0;
        return s;
    endfunction

    function automatic longint half_quad(longint unsigned a, longint unsigned dt);
        return longint'((a * dt * dt) / 64'd2000);
    endfunction

    // Advance the profile by one event word and return the point it yields.
    function automatic point_t advance_profile(event_word_t ev);
        longint unsigned a, v, ramp_ms, dt, dq;
        longint len_um, v_um, p;
        logic [31:0] diff;
        point_t r;
        a = (cfg_acc != 0) ? cfg_acc : 1;
        v = cfg_spd;
        ramp_ms = (v / a) * 1000;
        len_um = longint'(cfg_len) * 1000;
        v_um = longint'(v) * 1000;
        diff = ev.ms - seg_ms;
        dt = diff;
        dq = (dt < DQ_LIMIT) ? dt : DQ_LIMIT;
        case (ev.kind)
            KIND_TICK:
            begin
                case (prof_phase)
                    PH_ACCEL, PH_BACK_ACCEL:
                    begin
                        keep_acc = a;
                        keep_spd = clamp_spd(longint'(a * dq));
                        keep_pos = (prof_phase == PH_ACCEL) ? clamp_pos(half_quad(a, dq))
                                                            : clamp_pos(len_um - half_quad(a, dq));
                        if (dt >= ramp_ms)
                        begin
                            prof_phase = prof_phase + 3'd1;
                            seg_ms = ev.ms;
                            seg_pos = keep_pos;
                        end
                    end
                    PH_CRUISE, PH_BACK_CRUISE:
                    begin
                        keep_acc = 0;
                        keep_spd = clamp_spd(v_um);
                        if (prof_phase == PH_CRUISE)
                            p = clamp_pos(seg_pos + longint'(v * dt));
                        else
                            p = clamp_pos(seg_pos - longint'(v * dt));
                        keep_pos = p;
                        if ((prof_phase == PH_CRUISE) ? (len_um - p <= seg_pos)
                                                      : (p <= len_um - seg_pos))
                        begin
                            prof_phase = prof_phase + 3'd1;
                            seg_ms = ev.ms;
                            seg_pos = p;
                        end
                    end
                    PH_DECEL, PH_BACK_DECEL:
                    begin
                        if (dt >= ramp_ms)
                        begin
                            keep_pos = (prof_phase == PH_DECEL) ? clamp_pos(len_um) : 0;
                            keep_spd = 0;
                            keep_acc = 0;
                            prof_phase = (prof_phase == PH_DECEL) ? PH_HOLD : PH_IDLE;
                        end
                        else
                        begin
                            keep_acc = a;
                            keep_spd = clamp_spd(v_um - longint'(a * dt));
                            if (prof_phase == PH_DECEL)
                                keep_pos = clamp_pos(seg_pos + longint'(v * dt) - half_quad(a, dt));
                            else
                                keep_pos = clamp_pos(seg_pos - longint'(v * dt) - half_quad(a, dt));
                        end
                    end
                    default: ;
                endcase
            end
            KIND_EXTEND, KIND_RETRACT:
            begin
                prof_phase = (ev.kind == KIND_EXTEND) ? PH_ACCEL : PH_BACK_ACCEL;
                seg_ms = ev.ms;
                seg_pos = 0;
            end
            default:
            begin
                prof_phase = PH_IDLE;
                keep_pos = 0;
                keep_spd = 0;
                keep_acc = 0;
            end
        endcase
        r.phase = prof_phase;
        r.pos = keep_pos[24:0];
        r.spd = keep_spd[18:0];
        r.acc = keep_acc[5:0];
        return r;
    endfunction

    function automatic logic quiet_now();
        return cycle >= QUIET_LO && cycle < QUIET_HI;
    endfunction

    // Driver: predict on accept, then offer the next word or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_points.push_back(advance_profile('{kind, elapsed_ms}));
                words_in++;
            end
            if (!in_valid || in_ready)
            begin
                // hold back now and then, but never in the quiet window
                if (pending_events.size() > 0 && (quiet_now() || $urandom_range(99) >= 6))
                begin
                    event_word_t ev;
                    ev = pending_events.pop_front();
                    in_valid <= 1'b1;
                    kind <= ev.kind;
                    elapsed_ms <= ev.ms;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted point with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            cycle++;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_valid && out_ready)
            begin
                words_out++;
                if (expected_points.size() == 0)
                begin
                    $error("output word with nothing expected");
                    errors++;
                end
                else
                begin
                    point_t e;
                    e = expected_points.pop_front();
                    if (phase !== e.phase)
                    begin
                        $error("phase: expected %0d, got %0d", e.phase, phase);
                        errors++;
                    end
                    if (position_um !== e.pos)
                    begin
                        $error("position_um: expected %0d, got %0d", e.pos, position_um);
                        errors++;
                    end
                    if (speed_um_s !== e.spd)
                    begin
                        $error("speed_um_s: expected %0d, got %0d", e.spd, speed_um_s);
                        errors++;
                    end
                    if (accel_out_mm_s2 !== e.acc)
                    begin
                        $error("accel_out_mm_s2: expected %0d, got %0d", e.acc, accel_out_mm_s2);
                        errors++;
                    end
                end
            end
            // one long back-pressure stretch so the block fills and stalls its input
            if (cycle == HOLD_AT)
                hold_left = HOLD_LEN;
            else if (hold_left > 0)
                hold_left--;
            out_ready <= (hold_left == 0) && (quiet_now() || $urandom_range(99) >= 6);
            if (idle_cycles >= WATCHDOG)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [13:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TARGET: cfg_len = val;
            CFG_SPEED:  cfg_spd = val[8:0];
            CFG_ACCEL:  cfg_acc = val[5:0];
            default: ;
        endcase
    endtask

    task automatic push_event(logic [1:0] k, logic [31:0] ms);
        pending_events.push_back('{k, ms});
    endtask

    // Wait until every queued word has come back, then let the block settle.
    // Sample on the falling edge so that driver and monitor updates have landed.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || in_valid || expected_points.size() != 0
               || out_valid);
        repeat (100) @(posedge clk);
    endtask

    // Queue one extension or retraction run with random tick spacing;
    // advance the clock far enough that most runs reach their end.
    task automatic queue_run(logic [1:0] start_kind, int ticks);
        longint unsigned a, span;
        a = (cfg_acc != 0) ? cfg_acc : 1;
        span = 2 * (cfg_spd / a) * 1000 + ((cfg_spd != 0) ? cfg_len * 1000 / cfg_spd : 1000);
        push_event(start_kind, clock_ms);
        for (int i = 0; i < ticks; i++)
        begin
            clock_ms += $urandom_range(1, int'(span / (ticks / 2 + 1)) + 1);
            if ($urandom_range(99) < 4)
                push_event(2'($urandom_range(3)), $urandom);
            else
                push_event(KIND_TICK, clock_ms);
        end
    endtask

    initial
    begin
        int total;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default setting, idle ticks, full extension, hold, retraction,
        // abort mid-run, wrap of the sequence clock and field extremes.
        push_event(KIND_TICK, 32'd0);
        push_event(KIND_TICK, 32'hFFFF_FFFF);
        push_event(KIND_EXTEND, 32'd0);
        for (int t = 10000; t <= 140000; t += 10000)
            push_event(KIND_TICK, t);
        push_event(KIND_TICK, 32'd150000);
        push_event(KIND_RETRACT, 32'hFFFF_0000);
        push_event(KIND_TICK, 32'h0000_1000);
        push_event(KIND_TICK, 32'hFFFF_FFFF);
        push_event(KIND_ABORT, 32'hFFFF_FFFF);
        push_event(KIND_EXTEND, 32'hFFFF_FFF0);
        push_event(KIND_TICK, 32'hFFFF_FFEF);
        push_event(KIND_ABORT, 32'd0);
        drain();

        // Extreme settings: big target with zero speed and zero accel, then a fast short run.
        write_reg(CFG_TARGET, 14'h3FFF);
        write_reg(CFG_SPEED, 14'd0);
        write_reg(CFG_ACCEL, 14'd0);
        clock_ms = 0;
        queue_run(KIND_EXTEND, 6);
        queue_run(KIND_RETRACT, 6);
        drain();
        write_reg(CFG_TARGET, 14'd0);
        write_reg(CFG_SPEED, 14'h1FF);
        write_reg(CFG_ACCEL, 14'h3F);
        queue_run(KIND_EXTEND, 20);
        queue_run(KIND_RETRACT, 20);
        drain();

        // Random settings, mostly well-formed extend/retract cycles.
        total = words_in;
        while (total < 900)
        begin
            write_reg(CFG_TARGET, 14'(($urandom_range(9) == 0) ? $urandom : $urandom_range(3000)));
            write_reg(CFG_SPEED, 14'(($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 300)));
            write_reg(CFG_ACCEL, 14'($urandom));
            clock_ms = $urandom;
            for (int r = 0; r < 3; r++)
            begin
                queue_run(KIND_EXTEND, $urandom_range(10, 30));
                queue_run(KIND_RETRACT, $urandom_range(10, 30));
            end
            if ($urandom_range(3) == 0)
                push_event(KIND_ABORT, $urandom);
            drain();
            total = words_in;
        end

        $display("Covered %0d event words and %0d profile points over %0d cycles,",
                 words_in, words_out, cycle);
        $display("with random register settings, back-pressure and clock wrap.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
